// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the slab allocator modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/scsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab allocator package
// Word types, result codes, size-class limits and back-end state type.
// ----------------------------------------------------------------------------
`default_nettype none

package scsa_pkg;

    // Number of slab classes and the class code used for oversize requests.
    localparam int NUM_CLASSES = 6;
    localparam logic [2:0] OVERSIZE_CLASS = 3'd6;

    // Upper byte limit of each class, smallest first.
    localparam logic [9:0] CLASS_BYTES [NUM_CLASSES] = '{
        10'd16, 10'd32, 10'd64, 10'd128, 10'd256, 10'd512
    };

    // Depth of the command queue between front and back.
    localparam int Q_DEPTH = 2;

    // Request kinds.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ALLOC    = 2'd0,
        ST_FREED    = 2'd1,
        ST_EXHAUST  = 2'd2,
        ST_OVERSIZE = 2'd3
    } t_status;

    // Input word.
    typedef struct packed {
        logic        req_type;
        logic [15:0] req_size;
        logic [2:0]  free_class;
        logic [7:0]  free_slot;
    } t_req;

    // Result word.
    typedef struct packed {
        t_status     status;
        logic [2:0]  size_class;
        logic [7:0]  slot_index;
    } t_rsp;

    // Classified command passed from front to back.
    typedef struct packed {
        logic        is_free;
        logic [2:0]  cls;
        logic [7:0]  slot;
    } t_cmd;

    // Back-end sequencer states.
    typedef enum logic {
        BK_RUN  = 1'b0,
        BK_LINK = 1'b1
    } t_back_state;

endpackage

`default_nettype wire

// ===== sv/scsa_front.sv =====
// ----------------------------------------------------------------------------
// Slab allocator front end
// Accepts request words and classifies allocations into a size class.
// ----------------------------------------------------------------------------
`default_nettype none

module scsa_front #(
    parameter int HEADER_BYTES = 8
) (
    input  wire              i_valid,
    output logic             o_ready,
    input  scsa_pkg::t_req   i_req,
    output logic             o_push,
    output scsa_pkg::t_cmd   o_cmd,
    input  wire              i_q_ready
);
    import scsa_pkg::*;

    logic [16:0] total;
    logic [2:0]  alloc_cls;

    // Payload plus header, then the smallest class that holds it.
    always_comb begin
        total     = 17'(i_req.req_size) + 17'(HEADER_BYTES);
        alloc_cls = OVERSIZE_CLASS;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (total <= 17'(CLASS_BYTES[c])) begin
                alloc_cls = 3'(c);
            end
        end
    end

    // Build the command word; a free carries its class unchanged.
    always_comb begin
        o_cmd.is_free = (i_req.req_type == REQ_FREE);
        o_cmd.cls     = (i_req.req_type == REQ_FREE) ? i_req.free_class : alloc_cls;
        o_cmd.slot    = i_req.free_slot;
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

endmodule

`default_nettype wire

// ===== sv/scsa_queue.sv =====
// ----------------------------------------------------------------------------
// Slab allocator command queue
// Short FIFO that decouples classification from list processing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module scsa_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  scsa_pkg::t_cmd   i_cmd,
    output logic             o_ready,
    output logic             o_valid,
    output scsa_pkg::t_cmd   o_cmd,
    input  wire              i_pop
);
    import scsa_pkg::*;

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != QCW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + QAW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + QAW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

    // The fill level never passes the depth, and a lone pop drops it by one.
    `ASSERT_ALWAYS(a_q_bound, i_clk, i_rst_n, r_count <= QCW'(Q_DEPTH), "queue overfilled")
    `ASSERT_NEXT(a_q_pop, i_clk, i_rst_n, pop && !push, (r_count + QCW'(1)) == $past(r_count), "queue level wrong after pop")

endmodule

`default_nettype wire

// ===== sv/scsa_back.sv =====
// ----------------------------------------------------------------------------
// Slab allocator back end
// Holds list heads, use counts and the link memory; executes commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module scsa_back #(
    parameter int SLOTS_PER_CLASS = 256
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cmd_valid,
    input  scsa_pkg::t_cmd   i_cmd,
    output logic             o_cmd_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output scsa_pkg::t_rsp   o_rsp
);
    import scsa_pkg::*;

    // Only slots below 256 can ever be freed, so links exist for those alone.
    localparam int LINK_SLOTS = (SLOTS_PER_CLASS < 256) ? SLOTS_PER_CLASS : 256;
    localparam int LW         = (LINK_SLOTS > 1) ? $clog2(LINK_SLOTS) : 1;
    localparam int DEPTH      = NUM_CLASSES * LINK_SLOTS;
    localparam int AW         = $clog2(DEPTH);
    localparam int UW         = $clog2(SLOTS_PER_CLASS + 1);
    localparam int CW         = (UW > 8) ? UW : 8;

    t_back_state             r_state;
    t_back_state             n_state;
    logic [NUM_CLASSES-1:0]  r_head_vld;
    logic [NUM_CLASSES-1:0]  n_head_vld;
    logic [7:0]              r_head_slot [NUM_CLASSES];
    logic [7:0]              n_head_slot [NUM_CLASSES];
    logic [UW-1:0]           r_used [NUM_CLASSES];
    logic [UW-1:0]           n_used [NUM_CLASSES];
    logic [2:0]              r_pop_cls;
    logic                    r_out_valid;
    t_rsp                    r_rsp;
    t_rsp                    n_rsp;
    logic [8:0]              r_link_mem [DEPTH];
    logic [8:0]              r_rd_data;

    logic                    cmd_take;
    logic                    pop_start;
    logic                    mem_we;
    logic [AW-1:0]           mem_addr;
    logic [8:0]              mem_wdata;
    logic                    cls_ok;
    logic [2:0]              cls_i;
    logic [7:0]              addr_slot;

    // Class index guarded for the per-class arrays.
    assign cls_ok    = (i_cmd.cls < 3'(NUM_CLASSES));
    assign cls_i     = cls_ok ? i_cmd.cls : '0;
    assign addr_slot = i_cmd.is_free ? i_cmd.slot : r_head_slot[cls_i];
    assign mem_addr  = AW'(cls_i) * AW'(LINK_SLOTS) + AW'(addr_slot[LW-1:0]);
    assign mem_wdata = {r_head_vld[cls_i], r_head_slot[cls_i]};

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_RUN: begin
                if (pop_start) begin
                    n_state = BK_LINK;
                end
            end
            BK_LINK: begin
                n_state = BK_RUN;
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    // Command execution: result word, list and counter updates.
    always_comb begin
        cmd_take   = 1'b0;
        pop_start  = 1'b0;
        mem_we     = 1'b0;
        n_head_vld = r_head_vld;
        n_head_slot = r_head_slot;
        n_used     = r_used;
        n_rsp.status     = ST_FREED;
        n_rsp.size_class = i_cmd.cls;
        n_rsp.slot_index = '0;
        case (r_state)
            BK_RUN: begin
                cmd_take = i_cmd_valid && (!r_out_valid || i_ready);
                if (cmd_take) begin
                    if (!i_cmd.is_free) begin
                        if (!cls_ok) begin
                            n_rsp.status     = ST_OVERSIZE;
                            n_rsp.size_class = OVERSIZE_CLASS;
                        end else if (r_head_vld[cls_i]) begin
                            // Pop the list head; its link arrives next cycle.
                            n_rsp.status     = ST_ALLOC;
                            n_rsp.slot_index = r_head_slot[cls_i];
                            pop_start        = 1'b1;
                        end else if (r_used[cls_i] == UW'(SLOTS_PER_CLASS)) begin
                            n_rsp.status = ST_EXHAUST;
                        end else begin
                            n_rsp.status     = ST_ALLOC;
                            n_rsp.slot_index = 8'(r_used[cls_i]);
                            n_used[cls_i]    = r_used[cls_i] + UW'(1);
                        end
                    end else if (cls_ok && (CW'(i_cmd.slot) < CW'(r_used[cls_i]))) begin
                        // Push the freed slot in front of the current head.
                        mem_we             = 1'b1;
                        n_head_vld[cls_i]  = 1'b1;
                        n_head_slot[cls_i] = i_cmd.slot;
                    end
                end
            end
            BK_LINK: begin
                n_head_vld[r_pop_cls]  = r_rd_data[8];
                n_head_slot[r_pop_cls] = r_rd_data[7:0];
            end
            default: begin
                cmd_take = 1'b0;
            end
        endcase
    end

    assign o_cmd_pop = cmd_take;
    assign o_valid   = r_out_valid;
    assign o_rsp     = r_rsp;

    // Link memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link_mem[mem_addr] <= mem_wdata;
        end
        if (pop_start) begin
            r_rd_data <= r_link_mem[mem_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_head_vld  <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_used[c] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_head_vld <= n_head_vld;
            r_used     <= n_used;
            if (cmd_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_head_slot <= n_head_slot;
        if (cmd_take) begin
            r_rsp <= n_rsp;
        end
        if (pop_start) begin
            r_pop_cls <= cls_i;
        end
    end

    // The link wait returns to run in the next cycle and only ever follows a pop.
    `ASSERT_NEXT(a_link_one, i_clk, i_rst_n, r_state == BK_LINK, r_state == BK_RUN, "link wait too long")
    `ASSERT_ALWAYS(a_link_src, i_clk, i_rst_n, (r_state == BK_LINK) |-> $past(pop_start), "link wait without pop")

    // No class hands out more fresh slots than its pool holds.
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_used_chk
        `ASSERT_ALWAYS(a_used_bound, i_clk, i_rst_n, r_used[g] <= UW'(SLOTS_PER_CLASS), "use count beyond pool")
    end

endmodule

`default_nettype wire

// ===== sv/size_class_slab_allocator.sv =====
// Path: an accepted request word is registered in the command queue, then in the result register,
// where its result becomes valid. Throughput: one word per cycle while the receiver is ready;
// an allocation served from a free list adds a link wait to the back end, since the link memory
// read must return before the list head can be used again. Reset: list heads go empty and use
// counts go to zero; the link memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Size-class slab allocator
// Classifies allocate and free words and serves them from six LIFO free lists.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_slab_allocator #(
    parameter int SLOTS_PER_CLASS = 256,
    parameter int HEADER_BYTES    = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  scsa_pkg::t_req   i_req,
    output logic             o_valid,
    input  wire              i_ready,
    output scsa_pkg::t_rsp   o_rsp
);
    import scsa_pkg::*;

    logic  q_push;
    logic  q_ready;
    logic  q_valid;
    logic  q_pop;
    t_cmd  front_cmd;
    t_cmd  q_cmd;

    // Classification of incoming words.
    scsa_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_req     (i_req),
        .o_push    (q_push),
        .o_cmd     (front_cmd),
        .i_q_ready (q_ready)
    );

    // Decoupling queue.
    scsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // List processing and result register.
    scsa_back #(
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

// ===== tb/size_class_slab_allocator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slab allocator checker
// Watches the request and response channels, keeps its own copy of the free
// lists and use counts, and compares every response word with the one that
// the accepted request word should have produced.
// ----------------------------------------------------------------------------

module size_class_slab_allocator_checker #(
    parameter int SLOTS_PER_CLASS = 256,
    parameter int HEADER_BYTES    = 8
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_req_valid,
    input  wire             i_req_ready,
    input  scsa_pkg::t_req  i_req,
    input  wire             i_rsp_valid,
    input  wire             i_rsp_ready,
    input  scsa_pkg::t_rsp  i_rsp,
    output int              o_errors,
    output int              o_pending
);

    import scsa_pkg::*;

    // Shadow allocator state: list heads, link store and use counts.
    bit         head_valid [NUM_CLASSES];
    bit [7:0]   head_slot  [NUM_CLASSES];
    bit         link_valid [NUM_CLASSES*SLOTS_PER_CLASS];
    bit [7:0]   link_slot  [NUM_CLASSES*SLOTS_PER_CLASS];
    bit [8:0]   slots_used [NUM_CLASSES];

    t_rsp       pending_rsp_q [$];
    int         mismatch_count = 0;

    // Works out the response to one request word and updates the shadow state.
    function automatic t_rsp serve_request(t_req w);
        t_rsp       r;
        logic [16:0] total;
        logic [2:0]  cls;
        int          idx;
        r.status     = ST_FREED;
        r.size_class = w.free_class;
        r.slot_index = 8'd0;
        if (w.req_type == REQ_ALLOC) begin
            total = {1'b0, w.req_size} + 17'(HEADER_BYTES);
            cls   = OVERSIZE_CLASS;
            for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
                if (total <= (17'd16 << c)) begin
                    cls = 3'(c);
                end
            end
            r.size_class = cls;
            if (cls == OVERSIZE_CLASS) begin
                r.status = ST_OVERSIZE;
            end else if (head_valid[cls]) begin
                // Pop the head of the class list; its link becomes the new head.
                r.status         = ST_ALLOC;
                r.slot_index     = head_slot[cls];
                idx              = int'(cls) * SLOTS_PER_CLASS + int'(head_slot[cls]);
                head_valid[cls]  = link_valid[idx];
                head_slot[cls]   = link_slot[idx];
            end else if (slots_used[cls] >= 9'(SLOTS_PER_CLASS)) begin
                r.status = ST_EXHAUST;
            end else begin
                r.status         = ST_ALLOC;
                r.slot_index     = slots_used[cls][7:0];
                slots_used[cls]  = slots_used[cls] + 9'd1;
            end
        end else if (w.free_class < OVERSIZE_CLASS &&
                     {1'b0, w.free_slot} < slots_used[w.free_class]) begin
            // Push the freed slot; double frees are pushed again unchecked.
            idx                        = int'(w.free_class) * SLOTS_PER_CLASS +
                                         int'(w.free_slot);
            link_valid[idx]            = head_valid[w.free_class];
            link_slot[idx]             = head_slot[w.free_class];
            head_valid[w.free_class]   = 1'b1;
            head_slot[w.free_class]    = w.free_slot;
        end
        return r;
    endfunction

    // Responses are compared before the new request is predicted, since a
    // response can never appear in the same cycle as its own request word.
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            pending_rsp_q.delete();
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_valid[c] = 1'b0;
                slots_used[c] = 9'd0;
            end
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_rsp_q.size() == 0) begin
                    $error("response word with nothing outstanding: status %0d class %0d slot %0d",
                           i_rsp.status, i_rsp.size_class, i_rsp.slot_index);
                    mismatch_count++;
                end else begin
                    want = pending_rsp_q.pop_front();
                    if (i_rsp.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_rsp.status);
                        mismatch_count++;
                    end
                    if (i_rsp.size_class !== want.size_class) begin
                        $error("size_class: expected %0d, actual %0d",
                               want.size_class, i_rsp.size_class);
                        mismatch_count++;
                    end
                    if (i_rsp.slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot_index, i_rsp.slot_index);
                        mismatch_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                pending_rsp_q.push_back(serve_request(i_req));
            end
        end
        o_pending <= pending_rsp_q.size();
        o_errors  <= mismatch_count;
    end

endmodule

// ===== tb/size_class_slab_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slab allocator testbench
// Drives allocate and free words into the allocator with random gaps and
// back-pressure, frees slots that were actually handed out, runs bursts
// that exhaust a class pool, and leaves the checking to the checker module.
// ----------------------------------------------------------------------------

module size_class_slab_allocator_tb;

    import scsa_pkg::*;

    // Cycles without any accepted word before the run is abandoned.
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [2:0] cls;
        logic [7:0] slot;
    } t_held_slot;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_ready;
    t_req   i_req   = '0;
    logic   o_valid;
    logic   i_ready = 1'b0;
    t_rsp   o_rsp;

    int     failures;
    int     outstanding;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    logic   busy          = 1'b0;
    int     quiet_cycles  = 0;

    // Slots handed out and not yet freed, so that most frees are well formed.
    t_held_slot held_q [$];
    logic       grant_seen = 1'b0;
    t_held_slot grant_slot;

    size_class_slab_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    size_class_slab_allocator_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_req_ready (o_ready),
        .i_req       (i_req),
        .i_rsp_valid (o_valid),
        .i_rsp_ready (i_ready),
        .i_rsp       (o_rsp),
        .o_errors    (failures),
        .o_pending   (outstanding)
    );

    // Clock generation.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Capture granted slots at the rising edge, add them to the pool at the falling edge.
    always @(posedge i_clk) begin
        grant_seen <= o_valid && i_ready && o_rsp.status == ST_ALLOC;
        grant_slot <= '{cls: o_rsp.size_class, slot: o_rsp.slot_index};
    end

    always @(negedge i_clk) begin
        if (grant_seen) begin
            held_q.push_back(grant_slot);
        end
    end

    // Watchdog: while work is in flight, some word must move now and then.
    always @(posedge i_clk) begin
        if (!busy || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_req alloc_word(logic [15:0] size);
        t_req w;
        w.req_type   = REQ_ALLOC;
        w.req_size   = size;
        w.free_class = 3'($urandom);
        w.free_slot  = 8'($urandom);
        return w;
    endfunction

    function automatic t_req free_word(logic [2:0] cls, logic [7:0] slot);
        t_req w;
        w.req_type   = REQ_FREE;
        w.req_size   = 16'($urandom);
        w.free_class = cls;
        w.free_slot  = slot;
        return w;
    endfunction

    // A payload size whose total with the header lands in the given class.
    function automatic logic [15:0] size_for_class(int cls);
        int lo;
        int hi;
        lo = (cls == 0) ? 0 : (16 << (cls - 1)) - 8 + 1;
        hi = (16 << cls) - 8;
        return 16'($urandom_range(hi, lo));
    endfunction

    // Present one request word and hold it until it is accepted.
    task automatic send_word(t_req w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= w;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Mixed traffic: mostly class allocations and frees of held slots.
    task automatic run_mix(int count);
        int         pick;
        int         idx;
        t_held_slot h;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 80 && pick >= 45 && held_q.size() > 0) begin
                idx = $urandom_range(held_q.size() - 1, 0);
                h   = held_q[idx];
                held_q.delete(idx);
                send_word(free_word(h.cls, h.slot));
            end else if (pick < 80) begin
                send_word(alloc_word(size_for_class($urandom_range(5, 0))));
            end else if (pick < 88) begin
                send_word(alloc_word(16'($urandom_range(65535, 505))));
            end else if (pick < 94) begin
                send_word(free_word(3'($urandom), 8'($urandom)));
            end else begin
                send_word(alloc_word(16'($urandom)));
            end
        end
    endtask

    // A run of allocations in one class, long enough to drain its pool.
    task automatic run_burst(int cls, int count);
        repeat (count) begin
            send_word(alloc_word(size_for_class(cls)));
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        busy    <= 1'b1;

        // Directed words: class boundaries, header overflow, LIFO order,
        // double free and the free cases that leave the lists alone.
        send_idle_pct  = 31;
        recv_idle_pct <= 49;
        send_word(alloc_word(16'd0));
        send_word(alloc_word(16'd8));
        send_word(alloc_word(16'd9));
        send_word(alloc_word(16'd24));
        send_word(alloc_word(16'd25));
        send_word(alloc_word(16'd56));
        send_word(alloc_word(16'd120));
        send_word(alloc_word(16'd248));
        send_word(alloc_word(16'd504));
        send_word(alloc_word(16'd505));
        send_word(alloc_word(16'hFFFF));
        send_word(alloc_word(16'hFFF8));
        send_word(free_word(3'd0, 8'd1));
        send_word(free_word(3'd0, 8'd0));
        send_word(alloc_word(16'd0));
        send_word(alloc_word(16'd1));
        send_word(free_word(3'd0, 8'd0));
        send_word(free_word(3'd0, 8'd0));
        send_word(alloc_word(16'd2));
        send_word(alloc_word(16'd3));
        send_word(free_word(OVERSIZE_CLASS, 8'hFF));
        send_word(free_word(3'd7, 8'hFF));
        send_word(free_word(3'd5, 8'd200));
        send_word(free_word(3'd2, 8'hFF));

        // Sender idles less than the receiver; class 5 is run dry first.
        run_burst(5, 300);
        run_mix(420);

        // Receiver idles less than the sender.
        send_idle_pct  = 49;
        recv_idle_pct <= 31;
        run_mix(500);

        // Neither side idles; drain class 5 again at full rate.
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
        run_burst(5, 300);
        run_mix(300);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        busy <= 1'b0;
        repeat (16) @(posedge i_clk);

        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== size_class_slab_allocator.f =====
+incdir+sv
sv/scsa_pkg.sv
sv/scsa_front.sv
sv/scsa_queue.sv
sv/scsa_back.sv
sv/size_class_slab_allocator.sv
tb/size_class_slab_allocator_checker.sv
tb/size_class_slab_allocator_tb.sv
